// ===== rtl/core/char_lcd_nibble_sequencer_top_macros.svh =====
// assertion macros for the character lcd nibble sequencer
`ifndef CHAR_LCD_NIBBLE_SEQUENCER_TOP_MACROS_SVH
`define CHAR_LCD_NIBBLE_SEQUENCER_TOP_MACROS_SVH

// same-cycle implication, checked on i_clk outside reset
`define CLN_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on i_clk outside reset
`define CLN_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/cln_pkg.sv =====
// shared types, constants and functions of the character lcd nibble sequencer
package cln_pkg;

    // field widths
    localparam int REQ_TYPE_W = 3;
    localparam int BYTE_W     = 8;
    localparam int COL_W      = 6;
    localparam int PCT_W      = 7;
    localparam int SEG_W      = 5;
    localparam int NIB_W      = 4;
    localparam int ACC_W      = 11;
    localparam int PC_W       = 4;

    // request types
    localparam logic [REQ_TYPE_W-1:0] REQ_CMD    = 3'd0;
    localparam logic [REQ_TYPE_W-1:0] REQ_CHAR   = 3'd1;
    localparam logic [REQ_TYPE_W-1:0] REQ_CURSOR = 3'd2;
    localparam logic [REQ_TYPE_W-1:0] REQ_CLEAR  = 3'd3;
    localparam logic [REQ_TYPE_W-1:0] REQ_BAR    = 3'd4;

    // lcd bytes and bargraph constants
    localparam logic [SEG_W-1:0]  MAX_SEGMENTS = 5'd16;
    localparam logic [PCT_W-1:0]  PCT_MAX      = 7'd100;
    localparam logic [BYTE_W-1:0] CMD_CLEAR    = 8'h01;
    localparam logic [BYTE_W-1:0] CMD_DDRAM    = 8'h80;
    localparam logic [BYTE_W-1:0] ROW_STRIDE   = 8'd40;
    localparam logic [BYTE_W-1:0] GLYPH_FULL   = 8'h05;
    // product units: one pixel is 20, one full cell is 100
    localparam logic [ACC_W-1:0]  BAR_STEP     = 11'd100;
    localparam logic [ACC_W-1:0]  BAR_FULL_MIN = 11'd120;

    // emit codes
    localparam logic [1:0] EM_NONE = 2'd0;
    localparam logic [1:0] EM_POLL = 2'd1;
    localparam logic [1:0] EM_HI   = 2'd2;
    localparam logic [1:0] EM_LO   = 2'd3;

    // datapath load codes
    localparam logic [1:0] LD_NONE  = 2'd0;
    localparam logic [1:0] LD_HOME  = 2'd1;
    localparam logic [1:0] LD_GLYPH = 2'd2;

    // last-flag codes
    localparam logic [1:0] LS_NO  = 2'd0;
    localparam logic [1:0] LS_YES = 2'd1;
    localparam logic [1:0] LS_FIN = 2'd2;

    // sequencer jump codes
    localparam logic [2:0] JP_NEXT = 3'd0;
    localparam logic [2:0] JP_END  = 3'd1;
    localparam logic [2:0] JP_GOTO = 3'd2;
    localparam logic [2:0] JP_LOOP = 3'd3;
    localparam logic [2:0] JP_ZERO = 3'd4;

    // program entry points
    localparam logic [PC_W-1:0] PC_BYTE  = 4'd0;
    localparam logic [PC_W-1:0] PC_CLEAR = 4'd3;
    localparam logic [PC_W-1:0] PC_BAR   = 4'd6;
    localparam logic [PC_W-1:0] PC_LAST  = 4'd9;

    typedef struct packed {
        logic [1:0]      emit;
        logic [1:0]      load;
        logic [1:0]      last;
        logic [2:0]      jump;
        logic [PC_W-1:0] target;
    } t_ctrl;

    // control store
    function automatic t_ctrl f_microcode(input logic [PC_W-1:0] pc);
        t_ctrl w;
        w = '{emit: EM_NONE, load: LD_NONE, last: LS_NO, jump: JP_END, target: PC_BYTE};
        case (pc)
            // single byte
            4'd0: w = '{emit: EM_POLL, load: LD_NONE, last: LS_NO, jump: JP_NEXT,
                        target: PC_BYTE};
            4'd1: w = '{emit: EM_HI, load: LD_NONE, last: LS_NO, jump: JP_NEXT,
                        target: PC_BYTE};
            4'd2: w = '{emit: EM_LO, load: LD_NONE, last: LS_YES, jump: JP_END,
                        target: PC_BYTE};
            // clear, then home the cursor through the single byte routine
            4'd3: w = '{emit: EM_POLL, load: LD_NONE, last: LS_NO, jump: JP_NEXT,
                        target: PC_BYTE};
            4'd4: w = '{emit: EM_HI, load: LD_NONE, last: LS_NO, jump: JP_NEXT,
                        target: PC_BYTE};
            4'd5: w = '{emit: EM_LO, load: LD_HOME, last: LS_NO, jump: JP_GOTO,
                        target: PC_BYTE};
            // bargraph cell loop
            4'd6: w = '{emit: EM_NONE, load: LD_GLYPH, last: LS_NO, jump: JP_ZERO,
                        target: PC_BAR};
            4'd7: w = '{emit: EM_POLL, load: LD_NONE, last: LS_NO, jump: JP_NEXT,
                        target: PC_BAR};
            4'd8: w = '{emit: EM_HI, load: LD_NONE, last: LS_NO, jump: JP_NEXT,
                        target: PC_BAR};
            4'd9: w = '{emit: EM_LO, load: LD_NONE, last: LS_FIN, jump: JP_LOOP,
                        target: PC_BAR};
            default: w = '{emit: EM_NONE, load: LD_NONE, last: LS_NO, jump: JP_END,
                           target: PC_BYTE};
        endcase
        return w;
    endfunction

    // nibble bit reversal for the board wiring
    function automatic logic [NIB_W-1:0] f_rev(input logic [NIB_W-1:0] n);
        return {n[0], n[1], n[2], n[3]};
    endfunction

    // remainder glyph for a product below one full cell plus one pixel
    function automatic logic [BYTE_W-1:0] f_glyph(input logic [ACC_W-1:0] acc);
        logic [BYTE_W-1:0] g;
        if (acc >= 11'd100) begin
            g = 8'd5;
        end else if (acc >= 11'd80) begin
            g = 8'd4;
        end else if (acc >= 11'd60) begin
            g = 8'd3;
        end else if (acc >= 11'd40) begin
            g = 8'd2;
        end else if (acc >= 11'd20) begin
            g = 8'd1;
        end else begin
            g = 8'd0;
        end
        return g;
    endfunction

endpackage

// ===== rtl/core/cln_if.sv =====
// request and result channel interfaces of the character lcd nibble sequencer
interface cln_req_if import cln_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [REQ_TYPE_W-1:0] req_type;
    logic [BYTE_W-1:0]     byte_value;
    logic [COL_W-1:0]      column;
    logic                  row;
    logic [PCT_W-1:0]      percent;
    logic [SEG_W-1:0]      segment_count;

    modport source (output valid, req_type, byte_value, column, row, percent,
                    segment_count, input ready);
    modport sink (input valid, req_type, byte_value, column, row, percent,
                  segment_count, output ready);
endinterface

interface cln_res_if import cln_pkg::*;;
    logic             valid;
    logic             ready;
    logic             poll_busy;
    logic             register_select;
    logic [NIB_W-1:0] nibble;
    logic             last;

    modport source (output valid, poll_busy, register_select, nibble, last,
                    input ready);
    modport sink (input valid, poll_busy, register_select, nibble, last,
                  output ready);
endinterface

// ===== rtl/core/char_lcd_nibble_sequencer_top.sv =====
// top level of the character lcd nibble sequencer: microcoded request to bus transfers
// throughput: one microcode step per cycle unless an emitting step waits on a full output
// register; a byte is poll, high and low nibble steps, a bargraph cell adds a glyph load
// step first, and a bargraph with no segments ends at it with no result; a clear adds a
// cursor home byte; the input is held through all steps plus output stalls, then the step
// counter takes a new request even if the last result still waits in the output register
// reset (synchronous, active low) idles the sequencer and empties the output register
`include "char_lcd_nibble_sequencer_top_macros.svh"

module char_lcd_nibble_sequencer_top import cln_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cln_req_if.sink   i_req,
    cln_res_if.source o_res
);

    // control state
    logic            r_busy, n_busy;
    logic [PC_W-1:0] r_pc, n_pc;
    logic            r_ov, n_ov;

    // datapath
    logic [BYTE_W-1:0] r_byte, n_byte;
    logic              r_rs, n_rs;
    logic [ACC_W-1:0]  r_acc, n_acc;
    logic [SEG_W-1:0]  r_segs, n_segs;
    logic              r_fin, n_fin;

    // output register payload
    logic             r_poll, n_poll;
    logic             r_out_rs, n_out_rs;
    logic [NIB_W-1:0] r_nib, n_nib;
    logic             r_last, n_last;

    t_ctrl             w_ctrl;
    logic              w_acc;
    logic              w_step;
    logic              w_emit;
    logic              w_last;
    logic [PCT_W-1:0]  w_pct;
    logic [SEG_W-1:0]  w_segs;
    logic [BYTE_W-1:0] w_addr;

    // microcode fetch and step enable
    assign w_ctrl = f_microcode(r_pc);
    assign w_acc  = i_req.valid && i_req.ready;
    assign w_step = r_busy && ((w_ctrl.emit == EM_NONE) || !r_ov || o_res.ready);
    assign w_emit = w_step && (w_ctrl.emit != EM_NONE);

    assign i_req.ready = !r_busy;

    // request operand shaping
    assign w_pct  = (i_req.percent > PCT_MAX) ? PCT_MAX : i_req.percent;
    assign w_segs = (i_req.segment_count > MAX_SEGMENTS) ? MAX_SEGMENTS
                                                         : i_req.segment_count;
    assign w_addr = {2'b00, i_req.column} + (i_req.row ? ROW_STRIDE : 8'd0);

    // last flag of the current step
    always_comb begin
        case (w_ctrl.last)
            LS_YES:  w_last = 1'b1;
            LS_FIN:  w_last = r_fin;
            default: w_last = 1'b0;
        endcase
    end

    // next-state logic
    always_comb begin
        n_busy   = r_busy;
        n_pc     = r_pc;
        n_ov     = r_ov && !o_res.ready;
        n_byte   = r_byte;
        n_rs     = r_rs;
        n_acc    = r_acc;
        n_segs   = r_segs;
        n_fin    = r_fin;
        n_poll   = r_poll;
        n_out_rs = r_out_rs;
        n_nib    = r_nib;
        n_last   = r_last;

        if (w_acc) begin
            // request decode into a program entry point
            case (i_req.req_type)
                REQ_CMD: begin
                    n_busy = 1'b1;
                    n_pc   = PC_BYTE;
                    n_byte = i_req.byte_value;
                    n_rs   = 1'b0;
                end
                REQ_CHAR: begin
                    n_busy = 1'b1;
                    n_pc   = PC_BYTE;
                    n_byte = i_req.byte_value;
                    n_rs   = 1'b1;
                end
                REQ_CURSOR: begin
                    n_busy = 1'b1;
                    n_pc   = PC_BYTE;
                    n_byte = CMD_DDRAM | {1'b0, w_addr[6:0]};
                    n_rs   = 1'b0;
                end
                REQ_CLEAR: begin
                    n_busy = 1'b1;
                    n_pc   = PC_CLEAR;
                    n_byte = CMD_CLEAR;
                    n_rs   = 1'b0;
                end
                REQ_BAR: begin
                    n_busy = 1'b1;
                    n_pc   = PC_BAR;
                    n_rs   = 1'b1;
                    n_acc  = ACC_W'(w_pct) * ACC_W'(w_segs);
                    n_segs = w_segs;
                end
                default: begin
                end
            endcase
        end else if (w_step) begin
            // result emission
            case (w_ctrl.emit)
                EM_POLL: begin
                    n_ov     = 1'b1;
                    n_poll   = 1'b1;
                    n_out_rs = 1'b0;
                    n_nib    = '0;
                    n_last   = w_last;
                end
                EM_HI: begin
                    n_ov     = 1'b1;
                    n_poll   = 1'b0;
                    n_out_rs = r_rs;
                    n_nib    = f_rev(r_byte[7:4]);
                    n_last   = w_last;
                end
                EM_LO: begin
                    n_ov     = 1'b1;
                    n_poll   = 1'b0;
                    n_out_rs = r_rs;
                    n_nib    = f_rev(r_byte[3:0]);
                    n_last   = w_last;
                end
                default: begin
                end
            endcase

            // datapath loads
            case (w_ctrl.load)
                LD_HOME: begin
                    n_byte = CMD_DDRAM;
                end
                LD_GLYPH: begin
                    n_segs = r_segs - SEG_W'(1);
                    if (r_acc >= BAR_FULL_MIN) begin
                        n_byte = GLYPH_FULL;
                        n_acc  = r_acc - BAR_STEP;
                        n_fin  = (r_segs == SEG_W'(1));
                    end else begin
                        n_byte = f_glyph(r_acc);
                        n_fin  = 1'b1;
                    end
                end
                default: begin
                end
            endcase

            // step counter
            case (w_ctrl.jump)
                JP_NEXT: n_pc = r_pc + PC_W'(1);
                JP_GOTO: n_pc = w_ctrl.target;
                JP_END:  n_busy = 1'b0;
                JP_LOOP: begin
                    if (r_fin) begin
                        n_busy = 1'b0;
                    end else begin
                        n_pc = w_ctrl.target;
                    end
                end
                JP_ZERO: begin
                    if (r_segs == '0) begin
                        n_busy = 1'b0;
                    end else begin
                        n_pc = r_pc + PC_W'(1);
                    end
                end
                default: n_busy = 1'b0;
            endcase
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pc   <= PC_BYTE;
            r_ov   <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_pc   <= n_pc;
            r_ov   <= n_ov;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_byte   <= n_byte;
        r_rs     <= n_rs;
        r_acc    <= n_acc;
        r_segs   <= n_segs;
        r_fin    <= n_fin;
        r_poll   <= n_poll;
        r_out_rs <= n_out_rs;
        r_nib    <= n_nib;
        r_last   <= n_last;
    end

    // result channel
    assign o_res.valid           = r_ov;
    assign o_res.poll_busy       = r_poll;
    assign o_res.register_select = r_out_rs;
    assign o_res.nibble          = r_nib;
    assign o_res.last            = r_last;

    // checks
    `CLN_ASSERT_NXT(a_req_starts, w_acc && (i_req.req_type <= REQ_BAR), r_busy, "no start")
    `CLN_ASSERT_IMP(a_pc_range, r_busy, r_pc <= PC_LAST, "step counter outside the program")
    `CLN_ASSERT_NXT(a_last_ends, w_emit && w_last, !r_busy && r_ov && o_res.last, "bad end")
    `CLN_ASSERT_IMP(a_poll_fields, r_ov && r_poll, !r_out_rs && (r_nib == '0), "bad poll")

endmodule
